// File: hdl/sks_pkg.sv
package sks_pkg;

	// table geometry
	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int SLOT_W        = 6;
	localparam int LIM_W         = 7;

	// divider: 64-bit magnitude shifted left by 8 fraction bits
	localparam int DIV_STEPS = 72;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// operation codes
	localparam logic [1:0] OP_INGEST = 2'd0;
	localparam logic [1:0] OP_CLEAR  = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	// status codes
	localparam logic [2:0] ST_UPDATED    = 3'd0;
	localparam logic [2:0] ST_KEY_NEW    = 3'd1;
	localparam logic [2:0] ST_SENSOR_NEW = 3'd2;
	localparam logic [2:0] ST_KEY_DROP   = 3'd3;
	localparam logic [2:0] ST_SENS_DROP  = 3'd4;
	localparam logic [2:0] ST_RESET      = 3'd5;
	localparam logic [2:0] ST_REPORTED   = 3'd6;
	localparam logic [2:0] ST_EMPTY      = 3'd7;

	// configuration register indexes
	localparam logic [1:0] REG_KEY_LIM  = 2'd0;
	localparam logic [1:0] REG_SENS_LIM = 2'd1;

	// search token walking the cell row
	typedef struct packed {
		logic [1:0]        op;
		logic [63:0]       id;
		logic [63:0]       key;
		logic [31:0]       rdg;
		logic [SLOT_W-1:0] sel;
		logic              hit;
		logic              id_known;
		logic              free_found;
		logic [IDX_W-1:0]  hit_idx;
		logic [IDX_W-1:0]  free_idx;
		logic [31:0]       last;
		logic [31:0]       min;
		logic [31:0]       max;
		logic [63:0]       sum;
		logic [31:0]       cnt;
	} tok_t;

	// broadcast write / clear bus to the cells
	typedef struct packed {
		logic             clr;
		logic             en;
		logic [IDX_W-1:0] idx;
		logic [63:0]      id;
		logic [63:0]      key;
		logic [31:0]      last;
		logic [31:0]      min;
		logic [31:0]      max;
		logic [63:0]      sum;
		logic [31:0]      cnt;
	} wr_t;

endpackage

// File: hdl/sks_cell.sv
module sks_cell import sks_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] cell_idx,
	input  tok_t             tok_in,
	input  logic             vld_in,
	input  wr_t              wr,
	output tok_t             tok_out,
	output logic             vld_out
);

	logic        valid_q;
	logic [63:0] sensor_q;
	logic [63:0] key_q;
	logic [31:0] last_q;
	logic [31:0] min_q;
	logic [31:0] max_q;
	logic [63:0] sum_q;
	logic [31:0] cnt_q;
	tok_t        tok_q;
	logic        vld_q;
	tok_t        nxt;
	logic        id_eq;

	assign id_eq = valid_q && (sensor_q == tok_in.id);

	always_comb begin
		nxt = tok_in;
		if (tok_in.op == OP_INGEST) begin
			if (id_eq)
				nxt.id_known = 1'b1;
			if (id_eq && (key_q == tok_in.key) && !tok_in.hit) begin
				nxt.hit     = 1'b1;
				nxt.hit_idx = cell_idx;
				nxt.last    = last_q;
				nxt.min     = min_q;
				nxt.max     = max_q;
				nxt.sum     = sum_q;
				nxt.cnt     = cnt_q;
			end
			if (!valid_q && !tok_in.free_found) begin
				nxt.free_found = 1'b1;
				nxt.free_idx   = cell_idx;
			end
		end else if (32'(tok_in.sel) == 32'(cell_idx)) begin
			nxt.hit     = valid_q;
			nxt.hit_idx = cell_idx;
			nxt.last    = last_q;
			nxt.min     = min_q;
			nxt.max     = max_q;
			nxt.sum     = sum_q;
			nxt.cnt     = cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			vld_q   <= 1'b0;
		end else begin
			vld_q <= vld_in;
			if (wr.clr)
				valid_q <= 1'b0;
			else if (wr.en && (wr.idx == cell_idx))
				valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= nxt;
		if (wr.en && (wr.idx == cell_idx)) begin
			sensor_q <= wr.id;
			key_q    <= wr.key;
			last_q   <= wr.last;
			min_q    <= wr.min;
			max_q    <= wr.max;
			sum_q    <= wr.sum;
			cnt_q    <= wr.cnt;
		end
	end

	assign tok_out = tok_q;
	assign vld_out = vld_q;

endmodule

// File: hdl/sks_div.sv
module sks_div import sks_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] mag,
	input  logic [31:0] den,
	input  logic        neg,
	output logic        done,
	output logic [39:0] quot
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] n_q;
	logic [71:0]          dq_q;
	logic [31:0]          rem_q;
	logic [31:0]          den_q;
	logic                 neg_q;
	logic [32:0]          rem_sh;
	logic                 ge;

	assign rem_sh = {rem_q, dq_q[71]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			n_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			n_q    <= '0;
		end else if (busy_q) begin
			n_q <= n_q + DIV_CNT_W'(1);
			if (n_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= {mag, 8'd0};
			rem_q <= '0;
			den_q <= den;
			neg_q <= neg;
		end else if (busy_q) begin
			rem_q <= ge ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
			dq_q  <= {dq_q[70:0], ge};
		end
	end

	assign done = done_q;
	assign quot = neg_q ? (40'd0 - dq_q[39:0]) : dq_q[39:0];

endmodule

// File: hdl/sensor_key_stats_table.sv
// channel   | handshake            | payload
// ----------+----------------------+-------------------------------------------------
// input     | in_valid / in_ready  | operation, sensor_id, key_name, reading, slot_select
// result    | out_valid / out_ready| status, slot, last_value, min_value, max_value,
//           |                      | average_q8, sample_count
// config    | cfg_valid / cfg_ready| cfg_index (0 key limit, 1 sensor limit), cfg_data
//
// One request at a time. Ingest and read with data: the search token walks the
// row of TABLE_ENTRIES cells (one cell per cycle, 64 here), then the restoring
// divider forms the average. Dropped readings and empty reads still walk the row
// but skip the divider. Table resets skip both. Reset clears the valid bits and
// counts at once. An output register holds the last result, so a stalled out_ready
// only holds the next request once its own result is ready; config is always taken.
module sensor_key_stats_table import sks_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic [63:0]        sensor_id,
	input  logic [63:0]        key_name,
	input  logic signed [31:0] reading,
	input  logic [5:0]         slot_select,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic [5:0]         slot,
	output logic signed [31:0] last_value,
	output logic signed [31:0] min_value,
	output logic signed [31:0] max_value,
	output logic signed [39:0] average_q8,
	output logic [31:0]        sample_count,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [6:0]         cfg_data
);

	// controller states; S_OUT: result complete, waiting for the output register
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_CHAIN = 2'd1;
	localparam logic [1:0] S_DIV   = 2'd2;
	localparam logic [1:0] S_OUT   = 2'd3;

	logic [1:0]       st_q;
	logic [LIM_W-1:0] key_lim_q;
	logic [LIM_W-1:0] sens_lim_q;
	logic [LIM_W-1:0] keys_q;
	logic [LIM_W-1:0] sens_q;

	// working result
	logic [2:0]        status_q;
	logic [SLOT_W-1:0] slot_q;
	logic [31:0]       last_q;
	logic [31:0]       min_q;
	logic [31:0]       max_q;
	logic [39:0]       avg_q;
	logic [31:0]       cnt_q;

	// output register
	logic              out_valid_q;
	logic [2:0]        out_status_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [31:0]       out_last_q;
	logic [31:0]       out_min_q;
	logic [31:0]       out_max_q;
	logic [39:0]       out_avg_q;
	logic [31:0]       out_cnt_q;
	logic              move_out;

	logic accept;
	logic exit_tok;
	tok_t t;
	tok_t tok_head;
	wr_t  wr;

	// cell row
	tok_t                 chain_tok [TABLE_ENTRIES+1];
	logic [TABLE_ENTRIES:0] chain_vld;

	// decision on the token leaving the row
	logic [2:0]        d_status;
	logic [SLOT_W-1:0] d_slot;
	logic [31:0]       d_last;
	logic [31:0]       d_min;
	logic [31:0]       d_max;
	logic [63:0]       d_sum;
	logic [31:0]       d_cnt;
	logic              d_div;
	logic              d_key_inc;
	logic              d_sens_inc;
	logic [63:0]       rdg64;

	logic        div_done;
	logic [39:0] div_quot;
	logic [63:0] div_mag;

	assign in_ready  = (st_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign exit_tok  = (st_q == S_CHAIN) && chain_vld[TABLE_ENTRIES];
	assign t         = chain_tok[TABLE_ENTRIES];
	assign move_out  = (st_q == S_OUT) && (!out_valid_q || out_ready);

	// token enters the first cell straight from the request
	always_comb begin
		tok_head     = '0;
		tok_head.op  = operation;
		tok_head.id  = sensor_id;
		tok_head.key = key_name;
		tok_head.rdg = reading;
		tok_head.sel = slot_select;
	end
	assign chain_tok[0] = tok_head;
	assign chain_vld[0] = accept && ((operation == OP_INGEST) || (operation == OP_READ));

	for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
		sks_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(g)),
			.tok_in   (chain_tok[g]),
			.vld_in   (chain_vld[g]),
			.wr       (wr),
			.tok_out  (chain_tok[g+1]),
			.vld_out  (chain_vld[g+1])
		);
	end

	assign rdg64 = {{32{t.rdg[31]}}, t.rdg};

	always_comb begin
		d_status   = ST_EMPTY;
		d_slot     = '0;
		d_last     = '0;
		d_min      = '0;
		d_max      = '0;
		d_sum      = '0;
		d_cnt      = '0;
		d_div      = 1'b0;
		d_key_inc  = 1'b0;
		d_sens_inc = 1'b0;
		wr         = '0;
		wr.id      = t.id;
		wr.key     = t.key;
		if (t.op == OP_INGEST) begin
			if (t.hit) begin
				// existing pair: update in place, count saturates
				d_status = ST_UPDATED;
				d_slot   = SLOT_W'(t.hit_idx);
				d_last   = t.rdg;
				d_min    = ($signed(t.rdg) < $signed(t.min)) ? t.rdg : t.min;
				d_max    = ($signed(t.rdg) > $signed(t.max)) ? t.rdg : t.max;
				d_sum    = (t.cnt == '1) ? t.sum : t.sum + rdg64;
				d_cnt    = (t.cnt == '1) ? t.cnt : t.cnt + 32'd1;
				d_div    = 1'b1;
				wr.en    = exit_tok;
				wr.idx   = t.hit_idx;
			end else if (!t.id_known && (sens_q >= sens_lim_q)) begin
				d_status = ST_SENS_DROP;
			end else if ((keys_q >= key_lim_q) || !t.free_found) begin
				d_status = ST_KEY_DROP;
			end else begin
				// new entry at the lowest free cell
				d_status   = t.id_known ? ST_KEY_NEW : ST_SENSOR_NEW;
				d_slot     = SLOT_W'(t.free_idx);
				d_last     = t.rdg;
				d_min      = t.rdg;
				d_max      = t.rdg;
				d_sum      = rdg64;
				d_cnt      = 32'd1;
				d_div      = 1'b1;
				d_key_inc  = 1'b1;
				d_sens_inc = !t.id_known;
				wr.en      = exit_tok;
				wr.idx     = t.free_idx;
			end
		end else if (t.hit) begin
			d_status = ST_REPORTED;
			d_slot   = t.sel;
			d_last   = t.last;
			d_min    = t.min;
			d_max    = t.max;
			d_sum    = t.sum;
			d_cnt    = t.cnt;
			d_div    = 1'b1;
		end else begin
			d_status = ST_EMPTY;
			d_slot   = t.sel;
		end
		wr.last = d_last;
		wr.min  = d_min;
		wr.max  = d_max;
		wr.sum  = d_sum;
		wr.cnt  = d_cnt;
		// table reset wipes every valid bit at once
		wr.clr  = accept && (operation == OP_CLEAR);
	end

	assign div_mag = d_sum[63] ? (64'd0 - d_sum) : d_sum;

	sks_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (exit_tok && d_div),
		.mag    (div_mag),
		.den    (d_cnt),
		.neg    (d_sum[63]),
		.done   (div_done),
		.quot   (div_quot)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			key_lim_q  <= LIM_W'(64);
			sens_lim_q <= LIM_W'(64);
			keys_q     <= '0;
			sens_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_KEY_LIM)
					key_lim_q <= cfg_data;
				else if (cfg_index == REG_SENS_LIM)
					sens_lim_q <= cfg_data;
			end
			case (st_q)
				S_IDLE: begin
					if (accept) begin
						if (operation == OP_CLEAR) begin
							keys_q <= '0;
							sens_q <= '0;
							st_q   <= S_OUT;
						end else if (chain_vld[0]) begin
							st_q <= S_CHAIN;
						end
					end
				end
				S_CHAIN: begin
					if (exit_tok) begin
						if (d_key_inc)
							keys_q <= keys_q + LIM_W'(1);
						if (d_sens_inc)
							sens_q <= sens_q + LIM_W'(1);
						st_q <= d_div ? S_DIV : S_OUT;
					end
				end
				S_DIV: begin
					if (div_done)
						st_q <= S_OUT;
				end
				S_OUT: begin
					if (move_out)
						st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// working result register
	always_ff @(posedge clk) begin
		if (accept && (operation == OP_CLEAR)) begin
			status_q <= ST_RESET;
			slot_q   <= '0;
			last_q   <= '0;
			min_q    <= '0;
			max_q    <= '0;
			avg_q    <= '0;
			cnt_q    <= '0;
		end else if (exit_tok) begin
			status_q <= d_status;
			slot_q   <= d_slot;
			last_q   <= d_last;
			min_q    <= d_min;
			max_q    <= d_max;
			avg_q    <= '0;
			cnt_q    <= d_cnt;
		end else if ((st_q == S_DIV) && div_done) begin
			avg_q <= div_quot;
		end
	end

	// output register: parts a held result from the next request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (move_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (move_out) begin
			out_status_q <= status_q;
			out_slot_q   <= slot_q;
			out_last_q   <= last_q;
			out_min_q    <= min_q;
			out_max_q    <= max_q;
			out_avg_q    <= avg_q;
			out_cnt_q    <= cnt_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign slot         = out_slot_q;
	assign last_value   = out_last_q;
	assign min_value    = out_min_q;
	assign max_value    = out_max_q;
	assign average_q8   = out_avg_q;
	assign sample_count = out_cnt_q;

	// checks
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(chain_vld[TABLE_ENTRIES:1]))
		else $error("more than one token in the cell row");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !chain_vld[TABLE_ENTRIES])
		else $error("request taken while previous one is busy");

	a_sens_le_keys: assert property (@(posedge clk) disable iff (!arst_n)
		sens_q <= keys_q)
		else $error("more sensors than entries");

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((status == ST_KEY_DROP) || (status == ST_SENS_DROP)
		|| (status == ST_RESET)) |-> (slot == '0) && (sample_count == '0))
		else $error("dropped or reset result carries data");

endmodule

// File: tb/sensor_key_stats_table_tb.sv
module sensor_key_stats_table_tb import sks_pkg::*;;

	// one request as the sender holds it
	typedef struct {
		logic [1:0]         op;
		logic [63:0]        id;
		logic [63:0]        key;
		logic signed [31:0] rdg;
		logic [5:0]         sel;
	} request_t;

	// one result, field for field as on the ports
	typedef struct packed {
		logic [2:0]         status;
		logic [5:0]         slot;
		logic signed [31:0] last;
		logic signed [31:0] min;
		logic signed [31:0] max;
		logic signed [39:0] avg;
		logic [31:0]        cnt;
	} stats_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               in_valid, in_ready;
	logic [1:0]         operation;
	logic [63:0]        sensor_id, key_name;
	logic signed [31:0] reading;
	logic [5:0]         slot_select;
	logic               out_valid, out_ready;
	logic [2:0]         status;
	logic [5:0]         slot;
	logic signed [31:0] last_value, min_value, max_value;
	logic signed [39:0] average_q8;
	logic [31:0]        sample_count;
	logic               cfg_valid, cfg_ready;
	logic [1:0]         cfg_index;
	logic [6:0]         cfg_data;

	sensor_key_stats_table u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Predicted table: our own copy of every entry plus the limits
	// ---------------------------------------------------------------
	logic               tbl_valid [64];
	logic [63:0]        tbl_sensor[64];
	logic [63:0]        tbl_key   [64];
	logic signed [31:0] tbl_last  [64];
	logic signed [31:0] tbl_min   [64];
	logic signed [31:0] tbl_max   [64];
	logic signed [63:0] tbl_sum   [64];
	logic [31:0]        tbl_cnt   [64];
	logic [6:0]         keys_used, sensors_used;
	logic [6:0]         lim_keys, lim_sensors;

	request_t pending_reqs[$];
	stats_t   expected_stats[$];

	int mismatches = 0;
	int failures   = 0;
	bit no_idle    = 1'b0;

	function automatic void clear_table();
		for (int i = 0; i < 64; i++)
			tbl_valid[i] = 1'b0;
		keys_used = '0;
		sensors_used = '0;
	endfunction

	// sum/count in Q.8, magnitude divided then sign restored, truncated
	function automatic logic [39:0] average_of(logic signed [63:0] sum, logic [31:0] cnt);
		logic [63:0] mag, q, r, res;
		if (cnt == 0)
			return '0;
		mag = (sum < 0) ? -sum : sum;
		q   = mag / cnt;
		r   = mag % cnt;
		res = (q << 8) + ((r << 8) / cnt);
		if (sum < 0)
			res = -res;
		return res[39:0];
	endfunction

	function automatic stats_t entry_result(logic [2:0] st, int idx, bit with_data);
		stats_t s;
		s = '0;
		s.status = st;
		s.slot   = idx[5:0];
		if (with_data) begin
			s.last = tbl_last[idx];
			s.min  = tbl_min[idx];
			s.max  = tbl_max[idx];
			s.avg  = average_of(tbl_sum[idx], tbl_cnt[idx]);
			s.cnt  = tbl_cnt[idx];
		end
		return s;
	endfunction

	// works out the result of one accepted request and updates the table
	function automatic void apply_request(request_t r);
		int  pair, free_idx;
		bit  id_known;
		pair = -1;
		free_idx = -1;
		id_known = 1'b0;
		case (r.op)
			OP_INGEST: begin
				for (int i = 0; i < 64; i++) begin
					if (tbl_valid[i] && tbl_sensor[i] == r.id) begin
						id_known = 1'b1;
						if (tbl_key[i] == r.key) begin
							pair = i;
							break;
						end
					end
				end
				for (int i = 63; i >= 0; i--)
					if (!tbl_valid[i])
						free_idx = i;
				if (pair >= 0) begin
					tbl_last[pair] = r.rdg;
					if (r.rdg > tbl_max[pair])
						tbl_max[pair] = r.rdg;
					if (r.rdg < tbl_min[pair])
						tbl_min[pair] = r.rdg;
					// count saturates, sum freezes with it
					if (tbl_cnt[pair] != 32'hFFFF_FFFF) begin
						tbl_sum[pair] += r.rdg;
						tbl_cnt[pair]++;
					end
					expected_stats.push_back(entry_result(ST_UPDATED, pair, 1'b1));
				end else if (!id_known && sensors_used >= lim_sensors) begin
					expected_stats.push_back(entry_result(ST_SENS_DROP, 0, 1'b0));
				end else if (keys_used >= lim_keys || free_idx < 0) begin
					expected_stats.push_back(entry_result(ST_KEY_DROP, 0, 1'b0));
				end else begin
					tbl_valid[free_idx]  = 1'b1;
					tbl_sensor[free_idx] = r.id;
					tbl_key[free_idx]    = r.key;
					tbl_last[free_idx]   = r.rdg;
					tbl_min[free_idx]    = r.rdg;
					tbl_max[free_idx]    = r.rdg;
					tbl_sum[free_idx]    = r.rdg;
					tbl_cnt[free_idx]    = 1;
					keys_used++;
					if (!id_known)
						sensors_used++;
					expected_stats.push_back(entry_result(id_known ? ST_KEY_NEW : ST_SENSOR_NEW,
						free_idx, 1'b1));
				end
			end
			OP_CLEAR: begin
				clear_table();
				expected_stats.push_back(entry_result(ST_RESET, 0, 1'b0));
			end
			OP_READ: begin
				if (tbl_valid[r.sel])
					expected_stats.push_back(entry_result(ST_REPORTED, r.sel, 1'b1));
				else
					expected_stats.push_back(entry_result(ST_EMPTY, r.sel, 1'b0));
			end
			default: ; // undefined op: ignored, no result
		endcase
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (no_idle || p < 50)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// ---------------------------------------------------------------
	// Driver: presents queued requests, holds payload until taken
	// ---------------------------------------------------------------
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		request_t r;
		if (!arst_n) begin
			in_valid    <= 1'b0;
			operation   <= '0;
			sensor_id   <= '0;
			key_name    <= '0;
			reading     <= '0;
			slot_select <= '0;
			send_gap    <= 0;
		end else begin
			if (in_valid && in_ready) begin
				r.op  = operation;
				r.id  = sensor_id;
				r.key = key_name;
				r.rdg = reading;
				r.sel = slot_select;
				apply_request(r);
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					r = pending_reqs.pop_front();
					operation   <= r.op;
					sensor_id   <= r.id;
					key_name    <= r.key;
					reading     <= r.rdg;
					slot_select <= r.sel;
					in_valid    <= 1'b1;
					send_gap    <= pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor: random back-pressure, checks each result in order;
	// also tracks limit writes as the block takes them
	// ---------------------------------------------------------------
	int stall;
	always @(posedge clk or negedge arst_n) begin
		stats_t got, want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_KEY_LIM)
					lim_keys = cfg_data;
				else if (cfg_index == REG_SENS_LIM)
					lim_sensors = cfg_data;
			end
			if (out_valid && out_ready) begin
				got = {status, slot, last_value, min_value, max_value, average_q8, sample_count};
				if (expected_stats.size() == 0) begin
					failures++;
					$display("unexpected result %p", got);
				end else begin
					want = expected_stats.pop_front();
					if (got !== want) begin
						failures++;
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p, got %p", want, got);
					end
				end
			end
			if (stall > 0) begin
				stall <= stall - 1;
				out_ready <= 1'b0;
			end else begin
				stall <= pick_gap();
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog: idle cycles with no handshake on any channel
	int quiet = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= 5000) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	logic [63:0] id_pool [8];
	logic [63:0] key_pool[6];

	task automatic add_req(logic [1:0] op, logic [63:0] id, logic [63:0] key,
			logic signed [31:0] v, logic [5:0] sel);
		request_t r;
		r.op = op;
		r.id = id;
		r.key = key;
		r.rdg = v;
		r.sel = sel;
		pending_reqs.push_back(r);
	endtask

	// drain: nothing pending, nothing owed, then margin for silent ops;
	// sampled on the falling edge so the driver's updates have settled
	task automatic wait_drained();
		while (pending_reqs.size() > 0 || in_valid || expected_stats.size() > 0)
			@(negedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_limit(logic [1:0] idx, logic [6:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [31:0] pick_reading();
		case ($urandom_range(0, 5))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return $signed(32'($urandom_range(0, 20))) - 10;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int n_ids, n_keys, p;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		lim_keys = 7'd64;
		lim_sensors = 7'd64;
		clear_table();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, every op, creation, update, empty reads
		add_req(OP_INGEST, 64'h4142_4300_0000_0000, 64'h7465_6D70, 32'sh7FFF_FFFF, 0);
		add_req(OP_INGEST, 64'h4142_4300_0000_0000, 64'h7465_6D70, 32'sh8000_0000, 0);
		add_req(OP_INGEST, 64'h4142_4300_0000_0000, 64'h7465_6D70, -32'sd3, 0);
		add_req(OP_INGEST, 64'h4142_4300_0000_0000, 64'h6875_6D, 32'sd0, 0);
		add_req(OP_INGEST, '1, '1, -32'sd1, 6'h3F);
		add_req(OP_INGEST, '0, '0, 32'sd1, 0);
		add_req(OP_READ, 0, 0, 0, 6'd0);
		add_req(OP_READ, '1, '1, '1, 6'd2);
		add_req(OP_READ, 0, 0, 0, 6'd63);
		add_req(2'd3, '1, '1, '1, '1);
		add_req(OP_CLEAR, 0, 0, 0, 0);
		add_req(OP_READ, 0, 0, 0, 6'd0);
		wait_drained();

		// both limits at the bottom: key drop and sensor drop
		write_limit(REG_KEY_LIM, 7'd1);
		write_limit(REG_SENS_LIM, 7'd1);
		add_req(OP_INGEST, 64'h11, 64'h22, 32'sd5, 0);
		add_req(OP_INGEST, 64'h11, 64'h23, 32'sd6, 0);
		add_req(OP_INGEST, 64'h12, 64'h22, 32'sd7, 0);
		add_req(OP_INGEST, 64'h11, 64'h22, 32'sd9, 0);
		wait_drained();
		// new id passes the sensor test, then hits the key limit
		write_limit(REG_SENS_LIM, 7'd2);
		add_req(OP_INGEST, 64'h12, 64'h22, 32'sd7, 0);
		add_req(OP_CLEAR, 0, 0, 0, 0);
		wait_drained();

		// fill the whole table, one more must be refused
		write_limit(REG_KEY_LIM, 7'd64);
		write_limit(REG_SENS_LIM, 7'd64);
		for (int i = 0; i < 65; i++)
			add_req(OP_INGEST, 64'(i % 3), 64'(i), pick_reading(), 0);
		for (int i = 0; i < 4; i++)
			add_req(OP_READ, 0, 0, 0, 6'($urandom_range(0, 63)));
		wait_drained();

		// random phases: small id/key pools so pairs repeat and fill up
		for (p = 0; p < 8; p++) begin
			case (p)
				0: begin write_limit(REG_KEY_LIM, 7'd64); write_limit(REG_SENS_LIM, 7'd64); end
				1: begin write_limit(REG_KEY_LIM, 7'd1);  write_limit(REG_SENS_LIM, 7'd64); end
				2: begin write_limit(REG_KEY_LIM, 7'd64); write_limit(REG_SENS_LIM, 7'd1);  end
				default: begin
					write_limit(REG_KEY_LIM, 7'($urandom_range(1, 64)));
					write_limit(REG_SENS_LIM, 7'($urandom_range(1, 64)));
				end
			endcase
			no_idle = (p % 3 == 1);
			foreach (id_pool[i])
				id_pool[i] = {$urandom, $urandom};
			foreach (key_pool[i])
				key_pool[i] = {$urandom, $urandom};
			n_ids  = $urandom_range(1, 8);
			n_keys = $urandom_range(1, 6);
			for (int k = 0; k < 200; k++) begin
				int r;
				r = $urandom_range(0, 99);
				if (r < 70)
					add_req(OP_INGEST, id_pool[$urandom_range(0, n_ids - 1)],
						key_pool[$urandom_range(0, n_keys - 1)], pick_reading(),
						6'($urandom));
				else if (r < 76)
					add_req(OP_INGEST, {$urandom, $urandom}, {$urandom, $urandom},
						pick_reading(), 6'($urandom));
				else if (r < 96)
					add_req(OP_READ, {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
						($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 15)));
				else if (r < 98)
					add_req(OP_CLEAR, {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
						6'($urandom));
				else
					add_req(2'd3, {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
						6'($urandom));
			end
			// sender holds off until every result is back
			wait_drained();
		end

		failures += expected_stats.size();
		if (failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
